// File: rtl/acc_pkg.sv
// ----------------------------------------------------------------------------
// Alarm clock controller package
// Widths, reset values, register indexes and the counter saturation helper.
// ----------------------------------------------------------------------------
package acc_pkg;

   localparam int HOUR_W      = 5;
   localparam int MINUTE_W    = 6;
   localparam int SECOND_W    = 6;
   localparam int CFG_COUNT_W = 12;
   localparam int CSR_DATA_W  = 12;
   localparam int CSR_ADDR_W  = 3;

   // Width of the ring and snooze counters
   localparam int COUNT_BITS  = 12;

   localparam logic [SECOND_W-1:0] SECONDS_PER_MIN = SECOND_W'(60);
   localparam logic [MINUTE_W-1:0] MINUTES_PER_HR  = MINUTE_W'(60);
   localparam logic [HOUR_W-1:0]   HOURS_PER_DAY   = HOUR_W'(24);

   localparam logic [HOUR_W-1:0]      WAKE_HOUR_RST   = HOUR_W'(0);
   localparam logic [MINUTE_W-1:0]    WAKE_MINUTE_RST = MINUTE_W'(0);
   localparam logic [SECOND_W-1:0]    WAKE_SECOND_RST = SECOND_W'(3);
   localparam logic [CFG_COUNT_W-1:0] AUTO_MUTE_RST   = CFG_COUNT_W'(20);
   localparam logic [CFG_COUNT_W-1:0] SNOOZE_RST      = CFG_COUNT_W'(300);

   typedef logic [COUNT_BITS-1:0] count_type;

   typedef enum logic [CSR_ADDR_W-1:0] {
      CSR_WAKE_HOUR   = 3'd0,
      CSR_WAKE_MINUTE = 3'd1,
      CSR_WAKE_SECOND = 3'd2,
      CSR_AUTO_MUTE   = 3'd3,
      CSR_SNOOZE      = 3'd4
   } csr_addr_type;

   // Clamp a register value to the counter range
   function automatic count_type sat_count(input logic [CFG_COUNT_W-1:0] value);
      logic [31:0] wide;
      logic [31:0] limit;
      wide  = 32'(value);
      limit = (32'd1 << COUNT_BITS) - 32'd1;
      if (wide > limit) begin
         return '1;
      end
      return COUNT_BITS'(wide);
   endfunction

endpackage

// File: rtl/alarm_clock_controller.sv
// ----------------------------------------------------------------------------
// Alarm clock controller
// One-second-tick time of day with wake alarm, snooze, mute and auto-mute.
// ----------------------------------------------------------------------------
// Usage:
//   Each transfer on the req_ channel is one tick carrying the sampled
//   active-low snooze, mute and enable buttons. Each tick yields exactly
//   one transfer on the rsp_ channel with the new time of day and the
//   enabled, ringing and snoozed flags.
//   The result is registered: a tick's result appears in the cycle after
//   it is taken. Throughput is one tick per cycle while the receiver takes
//   results; the whole tick update is one pass of increment and compare
//   logic into the state and result registers.
//   When the receiver stalls, the result register holds its contents and
//   req_ready stays high only while that register is empty or being taken,
//   so a tick is accepted in the same cycle a waiting result leaves.
//   Reset clears the time to 00:00:00, arms the alarm, stops any ringing
//   or snooze, and loads the wake time 00:00:03, auto-mute after 20 ticks
//   and a snooze of 300 ticks. The user must make csr_ writes only while
//   the block is idle; the block itself does not enforce this.
// ----------------------------------------------------------------------------
module alarm_clock_controller (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              csr_we,
   input  logic [acc_pkg::CSR_ADDR_W-1:0]    csr_addr,
   input  logic [acc_pkg::CSR_DATA_W-1:0]    csr_wdata,
   input  logic                              req_valid,
   output logic                              req_ready,
   input  logic                              req_snooze_button,
   input  logic                              req_mute_button,
   input  logic                              req_enable_button,
   output logic                              rsp_valid,
   input  logic                              rsp_ready,
   output logic [acc_pkg::HOUR_W-1:0]        rsp_hour_now,
   output logic [acc_pkg::MINUTE_W-1:0]      rsp_minute_now,
   output logic [acc_pkg::SECOND_W-1:0]      rsp_second_now,
   output logic                              rsp_is_enabled,
   output logic                              rsp_is_ringing,
   output logic                              rsp_is_snoozed
);
   import acc_pkg::*;

   // Configuration
   logic [HOUR_W-1:0]      wake_hour_ff;
   logic [MINUTE_W-1:0]    wake_minute_ff;
   logic [SECOND_W-1:0]    wake_second_ff;
   logic [CFG_COUNT_W-1:0] auto_mute_ff;
   logic [CFG_COUNT_W-1:0] snooze_ticks_ff;

   // Clock state
   logic [HOUR_W-1:0]   hours_ff, hours_in;
   logic [MINUTE_W-1:0] minutes_ff, minutes_in;
   logic [SECOND_W-1:0] seconds_ff, seconds_in;
   logic                armed_ff, armed_in;
   logic                ringing_ff, ringing_in;
   logic                snoozing_ff, snoozing_in;
   count_type           ring_count_ff, ring_count_in;
   count_type           snooze_left_ff, snooze_left_in;
   logic                prev_snooze_ff, prev_mute_ff, prev_enable_ff;

   logic                rsp_valid_ff;
   logic                take;

   assign req_ready = !rsp_valid_ff || rsp_ready;
   assign take      = req_valid && req_ready;
   assign rsp_valid = rsp_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         wake_hour_ff    <= WAKE_HOUR_RST;
         wake_minute_ff  <= WAKE_MINUTE_RST;
         wake_second_ff  <= WAKE_SECOND_RST;
         auto_mute_ff    <= AUTO_MUTE_RST;
         snooze_ticks_ff <= SNOOZE_RST;
      end else if (csr_we) begin
         unique case (csr_addr)
            CSR_WAKE_HOUR:   wake_hour_ff    <= csr_wdata[HOUR_W-1:0];
            CSR_WAKE_MINUTE: wake_minute_ff  <= csr_wdata[MINUTE_W-1:0];
            CSR_WAKE_SECOND: wake_second_ff  <= csr_wdata[SECOND_W-1:0];
            CSR_AUTO_MUTE:   auto_mute_ff    <= csr_wdata[CFG_COUNT_W-1:0];
            CSR_SNOOZE:      snooze_ticks_ff <= csr_wdata[CFG_COUNT_W-1:0];
            default: ;
         endcase
      end
   end

   // One tick of the clock and alarm
   always_comb begin
      seconds_in     = seconds_ff + SECOND_W'(1);
      minutes_in     = minutes_ff;
      hours_in       = hours_ff;
      armed_in       = armed_ff;
      ringing_in     = ringing_ff;
      snoozing_in    = snoozing_ff;
      ring_count_in  = ring_count_ff;
      snooze_left_in = snooze_left_ff;

      // advance the time of day, wrap at midnight
      if (seconds_in >= SECONDS_PER_MIN) begin
         seconds_in = '0;
         minutes_in = minutes_ff + MINUTE_W'(1);
      end
      if (minutes_in >= MINUTES_PER_HR) begin
         minutes_in = '0;
         hours_in   = hours_ff + HOUR_W'(1);
      end
      if (hours_in >= HOURS_PER_DAY) begin
         hours_in = '0;
      end

      // button presses act on the falling edge only
      if (!req_snooze_button && prev_snooze_ff && ringing_in) begin
         ringing_in     = 1'b0;
         snoozing_in    = 1'b1;
         snooze_left_in = sat_count(snooze_ticks_ff);
         ring_count_in  = '0;
      end
      if (!req_mute_button && prev_mute_ff && (ringing_in || snoozing_in)) begin
         ringing_in     = 1'b0;
         snoozing_in    = 1'b0;
         ring_count_in  = '0;
         snooze_left_in = '0;
      end
      if (!req_enable_button && prev_enable_ff) begin
         armed_in = !armed_in;
         if (!armed_in) begin
            ringing_in     = 1'b0;
            snoozing_in    = 1'b0;
            ring_count_in  = '0;
            snooze_left_in = '0;
         end
      end

      if (armed_in && !ringing_in && !snoozing_in && hours_in == wake_hour_ff &&
          minutes_in == wake_minute_ff && seconds_in == wake_second_ff) begin
         ringing_in    = 1'b1;
         ring_count_in = '0;
      end

      // snooze expiry rings again
      if (snoozing_in) begin
         if (snooze_left_in <= count_type'(1)) begin
            snooze_left_in = '0;
            snoozing_in    = 1'b0;
            ringing_in     = 1'b1;
            ring_count_in  = '0;
         end else begin
            snooze_left_in = snooze_left_in - count_type'(1);
         end
      end

      if (ringing_in) begin
         ring_count_in = ring_count_in + count_type'(1);
         if (ring_count_in >= sat_count(auto_mute_ff)) begin
            ringing_in    = 1'b0;
            ring_count_in = '0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         hours_ff       <= '0;
         minutes_ff     <= '0;
         seconds_ff     <= '0;
         armed_ff       <= 1'b1;
         ringing_ff     <= 1'b0;
         snoozing_ff    <= 1'b0;
         ring_count_ff  <= '0;
         snooze_left_ff <= '0;
         prev_snooze_ff <= 1'b1;
         prev_mute_ff   <= 1'b1;
         prev_enable_ff <= 1'b1;
      end else if (take) begin
         hours_ff       <= hours_in;
         minutes_ff     <= minutes_in;
         seconds_ff     <= seconds_in;
         armed_ff       <= armed_in;
         ringing_ff     <= ringing_in;
         snoozing_ff    <= snoozing_in;
         ring_count_ff  <= ring_count_in;
         snooze_left_ff <= snooze_left_in;
         prev_snooze_ff <= req_snooze_button;
         prev_mute_ff   <= req_mute_button;
         prev_enable_ff <= req_enable_button;
      end
   end

   // Result register: hold while stalled
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (req_ready) begin
         rsp_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         rsp_hour_now   <= hours_in;
         rsp_minute_now <= minutes_in;
         rsp_second_now <= seconds_in;
         rsp_is_enabled <= armed_in;
         rsp_is_ringing <= ringing_in;
         rsp_is_snoozed <= snoozing_in;
      end
   end

`ifndef ASSERT_OFF
   a_ring_snooze_excl : assert property (@(posedge clock) disable iff (reset)
      !(ringing_ff && snoozing_ff))
      else $error("ringing and snoozed at once");

   a_disarmed_quiet : assert property (@(posedge clock) disable iff (reset)
      !armed_ff |-> (!ringing_ff && !snoozing_ff))
      else $error("alarm active while disarmed");

   a_ring_count_idle : assert property (@(posedge clock) disable iff (reset)
      !ringing_ff |-> (ring_count_ff == '0))
      else $error("ring counter left running");

   a_transfer_result : assert property (@(posedge clock) disable iff (reset)
      take |=> rsp_valid)
      else $error("accepted tick gave no result");
`endif

endmodule

// File: tb/alarm_clock_controller_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Alarm clock controller testbench
// Drives one-second ticks with pressed and released buttons under random
// back-pressure. A scoreboard model predicts the time of day and the alarm
// flags for every accepted tick and checks each result transfer against it.
// ----------------------------------------------------------------------------
module alarm_clock_controller_tb;
   import acc_pkg::*;

   localparam int CYCLE_LIMIT  = 1_000_000;
   localparam int SECS_PER_DAY = 86400;

   typedef struct packed {
      logic [HOUR_W-1:0]   hour;
      logic [MINUTE_W-1:0] minute;
      logic [SECOND_W-1:0] second;
      logic                enabled;
      logic                ringing;
      logic                snoozed;
   } clock_reading_type;

   class alarm_scoreboard;
      logic [HOUR_W-1:0]      wake_h;
      logic [MINUTE_W-1:0]    wake_m;
      logic [SECOND_W-1:0]    wake_s;
      logic [CFG_COUNT_W-1:0] mute_limit;
      logic [CFG_COUNT_W-1:0] snooze_len;

      logic [HOUR_W-1:0]      hh;
      logic [MINUTE_W-1:0]    mm;
      logic [SECOND_W-1:0]    ss;
      bit                     armed, ringing, snoozing;
      count_type              ring_cnt, snooze_left;
      bit                     prev_s, prev_m, prev_e;

      clock_reading_type      readings_due[$];
      int                     mismatches;

      function new();
         wake_h      = WAKE_HOUR_RST;
         wake_m      = WAKE_MINUTE_RST;
         wake_s      = WAKE_SECOND_RST;
         mute_limit  = AUTO_MUTE_RST;
         snooze_len  = SNOOZE_RST;
         hh          = '0;
         mm          = '0;
         ss          = '0;
         armed       = 1'b1;
         silence();
         prev_s      = 1'b1;
         prev_m      = 1'b1;
         prev_e      = 1'b1;
         mismatches  = 0;
      endfunction

      function void silence();
         ringing     = 1'b0;
         snoozing    = 1'b0;
         ring_cnt    = '0;
         snooze_left = '0;
      endfunction

      function count_type clamp_count(logic [CFG_COUNT_W-1:0] v);
         if (32'(v) > (2 ** COUNT_BITS) - 1) begin
            return '1;
         end
         return count_type'(v);
      endfunction

      function void set_reg(csr_addr_type idx, logic [CSR_DATA_W-1:0] v);
         case (idx)
            CSR_WAKE_HOUR:   wake_h = v[HOUR_W-1:0];
            CSR_WAKE_MINUTE: wake_m = v[MINUTE_W-1:0];
            CSR_WAKE_SECOND: wake_s = v[SECOND_W-1:0];
            CSR_AUTO_MUTE:   mute_limit = v[CFG_COUNT_W-1:0];
            CSR_SNOOZE:      snooze_len = v[CFG_COUNT_W-1:0];
            default: ;
         endcase
      endfunction

      // Advance one tick and queue the reading it should produce
      function void note_tick(logic snooze_lvl, logic mute_lvl, logic enable_lvl);
         clock_reading_type r;
         if (ss == SECONDS_PER_MIN - 1) begin
            ss = '0;
            if (mm == MINUTES_PER_HR - 1) begin
               mm = '0;
               hh = (hh == HOURS_PER_DAY - 1) ? '0 : hh + 1'b1;
            end else begin
               mm = mm + 1'b1;
            end
         end else begin
            ss = ss + 1'b1;
         end

         if (!snooze_lvl && prev_s && ringing) begin
            ringing     = 1'b0;
            snoozing    = 1'b1;
            snooze_left = clamp_count(snooze_len);
            ring_cnt    = '0;
         end
         if (!mute_lvl && prev_m && (ringing || snoozing)) begin
            silence();
         end
         if (!enable_lvl && prev_e) begin
            armed = !armed;
            if (!armed) begin
               silence();
            end
         end
         prev_s = snooze_lvl;
         prev_m = mute_lvl;
         prev_e = enable_lvl;

         if (armed && !ringing && !snoozing &&
             hh == wake_h && mm == wake_m && ss == wake_s) begin
            ringing  = 1'b1;
            ring_cnt = '0;
         end

         if (snoozing) begin
            if (snooze_left <= 1) begin
               snooze_left = '0;
               snoozing    = 1'b0;
               ringing     = 1'b1;
               ring_cnt    = '0;
            end else begin
               snooze_left = snooze_left - 1'b1;
            end
         end

         // A restart on this tick counts as the first ringing tick
         if (ringing) begin
            ring_cnt = ring_cnt + 1'b1;
            if (ring_cnt >= clamp_count(mute_limit)) begin
               ringing  = 1'b0;
               ring_cnt = '0;
            end
         end

         r.hour    = hh;
         r.minute  = mm;
         r.second  = ss;
         r.enabled = armed;
         r.ringing = ringing;
         r.snoozed = snoozing;
         readings_due.push_back(r);
      endfunction

      function void compare_field(string name, logic [31:0] exp_v, logic [31:0] got_v);
         if (got_v !== exp_v) begin
            $error("%s: expected %0d, got %0d", name, exp_v, got_v);
            mismatches++;
         end
      endfunction

      function void check_reading(clock_reading_type got);
         clock_reading_type exp_r;
         if (readings_due.size() == 0) begin
            $error("result transfer with no tick outstanding: %02d:%02d:%02d",
                   got.hour, got.minute, got.second);
            mismatches++;
            return;
         end
         exp_r = readings_due.pop_front();
         compare_field("hour_now",   32'(exp_r.hour),    32'(got.hour));
         compare_field("minute_now", 32'(exp_r.minute),  32'(got.minute));
         compare_field("second_now", 32'(exp_r.second),  32'(got.second));
         compare_field("is_enabled", 32'(exp_r.enabled), 32'(got.enabled));
         compare_field("is_ringing", 32'(exp_r.ringing), 32'(got.ringing));
         compare_field("is_snoozed", 32'(exp_r.snoozed), 32'(got.snoozed));
      endfunction

      function int pending();
         return readings_due.size();
      endfunction
   endclass

   logic                  clock = 1'b0;
   logic                  reset;
   logic                  csr_we;
   logic [CSR_ADDR_W-1:0] csr_addr;
   logic [CSR_DATA_W-1:0] csr_wdata;
   logic                  req_valid;
   logic                  req_ready;
   logic                  req_snooze_button;
   logic                  req_mute_button;
   logic                  req_enable_button;
   logic                  rsp_valid;
   logic                  rsp_ready = 1'b0;
   logic [HOUR_W-1:0]     rsp_hour_now;
   logic [MINUTE_W-1:0]   rsp_minute_now;
   logic [SECOND_W-1:0]   rsp_second_now;
   logic                  rsp_is_enabled;
   logic                  rsp_is_ringing;
   logic                  rsp_is_snoozed;

   alarm_scoreboard sb = new();

   int send_idle_pct = 0;
   int recv_idle_pct = 0;
   int hold_requests = 0;
   int holds_granted = 0;
   int hold_left     = 0;
   int ticks_sent    = 0;
   int cycle_count   = 0;

   alarm_clock_controller u_dut (
      .clock             (clock),
      .reset             (reset),
      .csr_we            (csr_we),
      .csr_addr          (csr_addr),
      .csr_wdata         (csr_wdata),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_snooze_button (req_snooze_button),
      .req_mute_button   (req_mute_button),
      .req_enable_button (req_enable_button),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_hour_now      (rsp_hour_now),
      .rsp_minute_now    (rsp_minute_now),
      .rsp_second_now    (rsp_second_now),
      .rsp_is_enabled    (rsp_is_enabled),
      .rsp_is_ringing    (rsp_is_ringing),
      .rsp_is_snoozed    (rsp_is_snoozed)
   );

   always #1 clock = ~clock;

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("Simulation FAILED");
         $finish;
      end
   end

   // Receiver: random stalls, plus a long hold-off when one is requested
   always @(negedge clock) begin
      if (hold_left > 0) begin
         rsp_ready <= 1'b0;
         hold_left <= hold_left - 1;
      end else if (holds_granted != hold_requests) begin
         holds_granted <= hold_requests;
         hold_left     <= 300;
         rsp_ready     <= 1'b0;
      end else begin
         rsp_ready <= ($urandom_range(99) >= recv_idle_pct);
      end
   end

   always @(posedge clock) begin : watch_results
      clock_reading_type got;
      if (!reset && rsp_valid && rsp_ready) begin
         got.hour    = rsp_hour_now;
         got.minute  = rsp_minute_now;
         got.second  = rsp_second_now;
         got.enabled = rsp_is_enabled;
         got.ringing = rsp_is_ringing;
         got.snoozed = rsp_is_snoozed;
         sb.check_reading(got);
      end
   end

   // Called and returns at a falling edge; valid stays high after the transfer
   task automatic send_tick(logic snooze_lvl, logic mute_lvl, logic enable_lvl);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid         <= 1'b1;
      req_snooze_button <= snooze_lvl;
      req_mute_button   <= mute_lvl;
      req_enable_button <= enable_lvl;
      do @(posedge clock); while (!req_ready);
      sb.note_tick(snooze_lvl, mute_lvl, enable_lvl);
      ticks_sent++;
      @(negedge clock);
   endtask

   // Drop valid and wait for every outstanding result to leave
   task automatic settle_block();
      req_valid <= 1'b0;
      while (sb.pending() != 0) @(negedge clock);
      repeat (2) @(negedge clock);
   endtask

   task automatic write_reg(csr_addr_type idx, int unsigned val);
      logic [CSR_DATA_W-1:0] w;
      int                    used;
      w = CSR_DATA_W'(val);
      case (idx)
         CSR_WAKE_HOUR:                    used = HOUR_W;
         CSR_WAKE_MINUTE, CSR_WAKE_SECOND: used = MINUTE_W;
         default:                          used = CSR_DATA_W;
      endcase
      // Junk above the register width must be dropped
      if (used < CSR_DATA_W && $urandom_range(7) == 0) begin
         w = w | (CSR_DATA_W'($urandom) << used);
      end
      csr_we    <= 1'b1;
      csr_addr  <= idx;
      csr_wdata <= w;
      sb.set_reg(idx, w);
      @(negedge clock);
   endtask

   task automatic program_wake(int unsigned h, int unsigned m, int unsigned s,
                               int unsigned mute_n, int unsigned snooze_n);
      write_reg(CSR_WAKE_HOUR, h);
      write_reg(CSR_WAKE_MINUTE, m);
      write_reg(CSR_WAKE_SECOND, s);
      write_reg(CSR_AUTO_MUTE, mute_n);
      write_reg(CSR_SNOOZE, snooze_n);
      csr_we <= 1'b0;
   endtask

   task automatic program_relative(int unsigned offset, int unsigned mute_n,
                                   int unsigned snooze_n);
      int unsigned t;
      t = (sb.hh * 3600 + sb.mm * 60 + sb.ss + offset) % SECS_PER_DAY;
      program_wake(t / 3600, (t / 60) % 60, t % 60, mute_n, snooze_n);
   endtask

   task automatic run_episode();
      int       n, pick, mute_n, snooze_n;
      int       press_left[3];
      int       press_pct[3];
      logic [2:0] lv;
      bit       noisy;
      settle_block();
      pick = $urandom_range(99);
      mute_n = (pick < 10) ? 0 : (pick < 15) ? 4095 : (pick < 20) ? 1
               : $urandom_range(2, 30);
      pick = $urandom_range(99);
      snooze_n = (pick < 10) ? 0 : (pick < 15) ? 4095 : (pick < 20) ? 1
                 : $urandom_range(2, 20);
      pick = $urandom_range(99);
      if (pick < 75) begin
         program_relative($urandom_range(1, 25), mute_n, snooze_n);
      end else if (pick < 90) begin
         program_wake($urandom_range(23), $urandom_range(59), $urandom_range(59),
                      mute_n, snooze_n);
      end else begin
         // Out-of-range wake time never matches
         program_wake($urandom_range(24, 31), $urandom_range(60, 63),
                      $urandom_range(63), mute_n, snooze_n);
      end

      press_pct[0] = 8;
      press_pct[1] = 5;
      press_pct[2] = 3;
      press_left   = '{0, 0, 0};
      noisy        = ($urandom_range(9) == 0);
      n            = $urandom_range(20, 60);
      repeat (n) begin
         for (int b = 0; b < 3; b++) begin
            if (noisy) begin
               lv[b] = 1'($urandom_range(1));
            end else if (press_left[b] > 0) begin
               lv[b] = 1'b0;
               press_left[b]--;
            end else if ($urandom_range(99) < press_pct[b]) begin
               lv[b] = 1'b0;
               press_left[b] = $urandom_range(2);
            end else begin
               lv[b] = 1'b1;
            end
         end
         send_tick(lv[0], lv[1], lv[2]);
      end
   endtask

   initial begin
      int mark;
      reset             = 1'b1;
      csr_we            = 1'b0;
      csr_addr          = CSR_WAKE_HOUR;
      csr_wdata         = '0;
      req_valid         = 1'b0;
      req_snooze_button = 1'b1;
      req_mute_button   = 1'b1;
      req_enable_button = 1'b1;
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // Reset settings: ring at 00:00:03, snooze, mute, enable toggles
      send_tick(1, 1, 1);
      send_tick(1, 1, 1);
      send_tick(1, 1, 1);
      send_tick(0, 1, 1);
      send_tick(0, 1, 1);
      send_tick(1, 0, 1);
      send_tick(1, 1, 1);
      send_tick(1, 1, 0);
      send_tick(1, 1, 1);
      send_tick(1, 1, 0);
      send_tick(0, 1, 1);
      send_tick(1, 0, 1);
      send_tick(0, 0, 0);
      send_tick(1, 1, 1);
      send_tick(1, 1, 0);

      // Zero snooze: snoozing rings again on the same tick
      settle_block();
      program_relative(2, 3, 0);
      send_tick(1, 1, 1);
      send_tick(1, 1, 1);
      send_tick(0, 1, 1);
      send_tick(1, 1, 1);
      send_tick(1, 1, 1);

      // Zero auto-mute silences on the first counted tick
      settle_block();
      program_relative(1, 0, 4095);
      send_tick(1, 1, 1);
      send_tick(1, 1, 1);

      settle_block();
      program_wake(31, 63, 63, 4095, 1);
      send_tick(1, 1, 1);
      send_tick(1, 1, 1);

      send_idle_pct = 6;
      recv_idle_pct = 52;
      mark = ticks_sent;
      while (ticks_sent - mark < 630) begin
         if (hold_requests == 0 && ticks_sent - mark > 200) begin
            // Keep offering ticks while the receiver holds off
            hold_requests++;
            repeat (20) send_tick(1, 1, 1);
         end
         run_episode();
      end

      send_idle_pct = 52;
      recv_idle_pct = 6;
      mark = ticks_sent;
      while (ticks_sent - mark < 630) run_episode();

      send_idle_pct = 0;
      recv_idle_pct = 0;
      mark = ticks_sent;
      while (ticks_sent - mark < 630) run_episode();

      req_valid <= 1'b0;
      while (sb.pending() != 0) @(posedge clock);
      repeat (8) @(posedge clock);
      if (sb.mismatches == 0) begin
         $display("Simulation PASSED");
      end else begin
         $display("Simulation FAILED");
      end
      $finish;
   end

endmodule
